// ===== rtl/bwo_pkg.sv =====
// Shared constants, codes and beat types of the band-limited wavetable oscillator.
package bwo_pkg;

  // Store geometry and number formats
  localparam int TABLE_SAMPLES = 2048;
  localparam int NUM_TABLES    = 16;
  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 16;

  localparam int ADDR_W  = $clog2(TABLE_SAMPLES);
  localparam int TIDX_W  = $clog2(NUM_TABLES);
  localparam int RAM_AW  = TIDX_W + ADDR_W;
  localparam int PHASE_W = ADDR_W + FRACTION_BITS;
  localparam int THR_W   = 24;
  localparam int NTAB_W  = 5;
  localparam int LEN_W   = 11;
  localparam int CMD_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W   = 27;

  // Reset values of the configuration registers
  localparam logic [NTAB_W-1:0] NUM_TABLES_RST   = NTAB_W'(1);
  localparam logic [LEN_W-1:0]  TABLE_LENGTH_RST = LEN_W'(2047);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK      = 2'd0,
    CMD_WR_SAMPLE = 2'd1,
    CMD_WR_THRESH = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_INC  = 2'd0,
    CFG_FREQ_RATIO = 2'd1,
    CFG_NUM_TABLES = 2'd2,
    CFG_TABLE_LEN  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    cmd_e                     command;
    logic [3:0]               table_number;
    logic [10:0]              sample_address;
    logic signed [15:0]       sample_value;
    logic [23:0]              threshold_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic [3:0]         table_in_use;
  } out_beat_t;

endpackage

// ===== rtl/bwo_sample_ram.sv =====
// Sample memory: one write port and two registered read ports.
module bwo_sample_ram (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [bwo_pkg::RAM_AW-1:0]        wr_addr_i,
  input  logic [bwo_pkg::SAMPLE_BITS-1:0]   wr_data_i,
  input  logic                              rd_en_i,
  input  logic [bwo_pkg::RAM_AW-1:0]        rd_addr0_i,
  input  logic [bwo_pkg::RAM_AW-1:0]        rd_addr1_i,
  output logic [bwo_pkg::SAMPLE_BITS-1:0]   rd_data0_o,
  output logic [bwo_pkg::SAMPLE_BITS-1:0]   rd_data1_o
);
  import bwo_pkg::*;

  logic [SAMPLE_BITS-1:0] mem [NUM_TABLES*TABLE_SAMPLES];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read ports; data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data0_o <= mem[rd_addr0_i];
      rd_data1_o <= mem[rd_addr1_i];
    end
  end

endmodule

// ===== rtl/bwo_table_sel.sv =====
// Threshold registers and band-limited table choice.
module bwo_table_sel (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [bwo_pkg::TIDX_W-1:0]    wr_table_i,
  input  logic [bwo_pkg::THR_W-1:0]     wr_thresh_i,
  input  logic [bwo_pkg::THR_W-1:0]     freq_ratio_i,
  input  logic [bwo_pkg::NTAB_W-1:0]    num_tables_i,
  output logic [bwo_pkg::TIDX_W-1:0]    table_o
);
  import bwo_pkg::*;

  logic [THR_W-1:0]  thresh_q [NUM_TABLES];
  logic [TIDX_W-1:0] last_idx;
  logic              found;

  // Threshold writes; contents undefined until written
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      thresh_q[wr_table_i] <= wr_thresh_i;
    end
  end

  // Last table in use, count clamped to 1..NUM_TABLES
  always_comb begin
    if (num_tables_i == '0) begin
      last_idx = '0;
    end else if (num_tables_i > NTAB_W'(NUM_TABLES)) begin
      last_idx = TIDX_W'(NUM_TABLES - 1);
    end else begin
      last_idx = TIDX_W'(num_tables_i - NTAB_W'(1));
    end
  end

  // First table whose threshold exceeds the ratio, capped at the last one
  always_comb begin
    table_o = last_idx;
    found   = 1'b0;
    for (int k = 0; k < NUM_TABLES; k++) begin
      if (!found && (TIDX_W'(k) < last_idx) && (freq_ratio_i < thresh_q[k])) begin
        table_o = TIDX_W'(k);
        found   = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bwo_phase.sv =====
// Phase accumulator with wrap and clamp, and read position generation.
module bwo_phase (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_i,
  input  logic [bwo_pkg::PHASE_W-1:0]   phase_inc_i,
  input  logic [bwo_pkg::LEN_W-1:0]     table_length_i,
  output logic [bwo_pkg::ADDR_W-1:0]    idx0_o,
  output logic [bwo_pkg::ADDR_W-1:0]    idx1_o,
  output logic [bwo_pkg::FRACTION_BITS-1:0] frac_o
);
  import bwo_pkg::*;

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [LEN_W-1:0]   len_eff;
  logic [PHASE_W-1:0] limit;
  logic [PHASE_W-1:0] limit_m1;
  logic [PHASE_W-1:0] read_pos;
  logic [PHASE_W:0]   sum;
  logic [PHASE_W+1:0] over1;
  logic [PHASE_W+1:0] over2;

  // Effective length, zero read as one
  assign len_eff  = (table_length_i == '0) ? LEN_W'(1) : table_length_i;
  assign limit    = {ADDR_W'(len_eff), FRACTION_BITS'(0)};
  assign limit_m1 = limit - PHASE_W'(1);

  // Read position clamped below the length
  assign read_pos = (phase_q >= limit) ? limit_m1 : phase_q;
  assign idx0_o   = read_pos[PHASE_W-1:FRACTION_BITS];
  assign idx1_o   = idx0_o + ADDR_W'(1);
  assign frac_o   = read_pos[FRACTION_BITS-1:0];

  // Next phase: sum, sum minus length, sum minus twice the length in parallel
  assign sum   = {1'b0, phase_q} + {1'b0, phase_inc_i};
  assign over1 = {1'b0, sum} - {2'b0, limit};
  assign over2 = {1'b0, sum} - {1'b0, limit, 1'b0};

  always_comb begin
    if (over1[PHASE_W+1]) begin
      phase_d = sum[PHASE_W-1:0];
    end else if (over2[PHASE_W+1]) begin
      phase_d = over1[PHASE_W-1:0];
    end else begin
      phase_d = limit_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (tick_i) begin
      phase_q <= phase_d;
    end
  end

endmodule

// ===== rtl/bwo_interp.sv =====
// Interpolation pipeline: sample stage, product stage and output register.
module bwo_interp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              issue_i,
  input  logic [bwo_pkg::FRACTION_BITS-1:0] frac_i,
  input  logic [bwo_pkg::TIDX_W-1:0]        table_i,
  input  logic [bwo_pkg::SAMPLE_BITS-1:0]   rd_data0_i,
  input  logic [bwo_pkg::SAMPLE_BITS-1:0]   rd_data1_i,
  output logic                              ready_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output bwo_pkg::out_beat_t                out_beat_o
);
  import bwo_pkg::*;

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = DIFF_W + FRACTION_BITS + 1;
  localparam int SUM_W  = SAMPLE_BITS + FRACTION_BITS + 3;

  logic                     v1_q, v2_q, v3_q;
  logic                     en1, en2, en3;
  logic [FRACTION_BITS-1:0] frac1_q;
  logic [TIDX_W-1:0]        tidx1_q, tidx2_q;
  logic signed [SAMPLE_BITS-1:0] v0_2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SAMPLE_BITS-1:0] s0, s1;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [SUM_W-1:0]  acc;
  logic signed [SUM_W-1:0]  acc_biased;
  out_beat_t                out_q;

  // Stage enables: a stage moves when the next one is empty or moving
  assign en3     = !v3_q || !out_stall_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  // Difference and fraction product
  assign s0     = $signed(rd_data0_i);
  assign s1     = $signed(rd_data1_i);
  assign diff   = DIFF_W'(s1) - DIFF_W'(s0);
  assign prod_d = $signed({1'b0, frac1_q}) * diff;

  // Sum and truncation toward zero
  assign acc        = (SUM_W'(v0_2_q) <<< FRACTION_BITS) + SUM_W'(prod_q);
  assign acc_biased = acc + (acc[SUM_W-1] ? SUM_W'((1 << FRACTION_BITS) - 1) : SUM_W'(0));

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= issue_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      frac1_q <= frac_i;
      tidx1_q <= table_i;
    end
    if (en2 && v1_q) begin
      prod_q  <= prod_d;
      v0_2_q  <= s0;
      tidx2_q <= tidx1_q;
    end
    if (en3 && v2_q) begin
      out_q.sample_out   <= acc_biased[FRACTION_BITS+SAMPLE_BITS-1:FRACTION_BITS];
      out_q.table_in_use <= tidx2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_beat_o  = out_q;

endmodule

// ===== rtl/bandlimited_wavetable_oscillator_top.sv =====
// An accepted tick beat passes the sample stage, product stage and output register in turn.
// Throughput: one beat per cycle unless stalled; the dual-read memory serves both neighbors.
// Write beats give no output; a later tick sees the write.
// Reset clears phase, pipeline valids and the configuration registers to their defaults.
// Sample and threshold stores are undefined until written and get no clearing pass.
module bandlimited_wavetable_oscillator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bwo_pkg::in_beat_t             in_beat_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bwo_pkg::out_beat_t            out_beat_o,
  input  logic                          cfg_we_i,
  input  logic [bwo_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bwo_pkg::CFG_W-1:0]     cfg_data_i
);
  import bwo_pkg::*;

  logic [PHASE_W-1:0] phase_inc_q;
  logic [THR_W-1:0]   freq_ratio_q;
  logic [NTAB_W-1:0]  num_tables_q;
  logic [LEN_W-1:0]   table_length_q;

  logic               ready;
  logic               accept;
  logic               tick;
  logic               wr_sample;
  logic               wr_thresh;
  logic [TIDX_W-1:0]  table_sel;
  logic [ADDR_W-1:0]  idx0, idx1;
  logic [FRACTION_BITS-1:0] frac;
  logic [SAMPLE_BITS-1:0]   rd_data0, rd_data1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q    <= '0;
      freq_ratio_q   <= '0;
      num_tables_q   <= NUM_TABLES_RST;
      table_length_q <= TABLE_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PHASE_INC:  phase_inc_q    <= cfg_data_i[PHASE_W-1:0];
        CFG_FREQ_RATIO: freq_ratio_q   <= cfg_data_i[THR_W-1:0];
        CFG_NUM_TABLES: num_tables_q   <= cfg_data_i[NTAB_W-1:0];
        CFG_TABLE_LEN:  table_length_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input beat decode
  assign in_stall_o = !ready;
  assign accept     = in_valid_i && ready;
  assign tick       = accept && (in_beat_i.command == CMD_TICK);
  assign wr_sample  = accept && (in_beat_i.command == CMD_WR_SAMPLE);
  assign wr_thresh  = accept && (in_beat_i.command == CMD_WR_THRESH);

  bwo_table_sel u_table_sel (
    .clk_i        (clk_i),
    .wr_en_i      (wr_thresh),
    .wr_table_i   (in_beat_i.table_number),
    .wr_thresh_i  (in_beat_i.threshold_value),
    .freq_ratio_i (freq_ratio_q),
    .num_tables_i (num_tables_q),
    .table_o      (table_sel)
  );

  bwo_phase u_phase (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_i         (tick),
    .phase_inc_i    (phase_inc_q),
    .table_length_i (table_length_q),
    .idx0_o         (idx0),
    .idx1_o         (idx1),
    .frac_o         (frac)
  );

  bwo_sample_ram u_sample_ram (
    .clk_i      (clk_i),
    .wr_en_i    (wr_sample),
    .wr_addr_i  ({in_beat_i.table_number, in_beat_i.sample_address}),
    .wr_data_i  (in_beat_i.sample_value),
    .rd_en_i    (tick),
    .rd_addr0_i ({table_sel, idx0}),
    .rd_addr1_i ({table_sel, idx1}),
    .rd_data0_o (rd_data0),
    .rd_data1_o (rd_data1)
  );

  bwo_interp u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (tick),
    .frac_i      (frac),
    .table_i     (table_sel),
    .rd_data0_i  (rd_data0),
    .rd_data1_i  (rd_data1),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
